### rtl/rfc_pkg.sv
// rfc_pkg: shared constants, codes and control structs of the frame cache
// used by rfc_ctrl, rfc_dp and retransmit_frame_cache
package rfc_pkg;

    localparam int unsigned Depth = 64;
    localparam int unsigned PtrW = $clog2(Depth);
    localparam int unsigned CntW = $clog2(Depth + 1);

    localparam logic [1:0] OP_STORE  = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic CFG_MAX_FRAMES = 1'b0;
    localparam logic CFG_RETENTION  = 1'b1;

    localparam logic [31:0] RetentionReset = 32'd1000;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;        // capture the input beat
        logic clear;        // empty the ring
        logic pop;          // drop head entry
        logic write;        // append latched entry
        logic scan_start;   // reset scan offset, start reading head
        logic scan_step;    // advance scan offset
        logic hit;          // record hit for current scanned entry
        logic miss;         // record a miss
        logic rd_head;      // issue memory read at head
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic empty_frame;  // store with zero count or length
        logic full;
        logic expired;      // head entry (read data) has expired
        logic over_limit;
        logic has_entries;
        logic match;        // scanned entry matches query
        logic scan_last;    // scanned entry is the newest
    } t_sts;

endpackage

### rtl/rfc_dp.sv
// rfc_dp: ring memory, counters, find compare and result registers
// depends on rfc_pkg
module rfc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rfc_pkg::t_cmd        i_cmd,
    output rfc_pkg::t_sts        o_sts,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic [1:0]           i_op,
    input  logic [31:0]          i_sequence_req,
    input  logic [15:0]          i_fragment_count,
    input  logic [31:0]          i_frame_number,
    input  logic [47:0]          i_capture_time,
    input  logic                 i_key_frame,
    input  logic [23:0]          i_data_length,
    input  logic [47:0]          i_now_time,
    output logic [1:0]           o_op,
    output logic                 o_hit,
    output logic [15:0]          o_fragment_index,
    output logic [15:0]          o_found_count,
    output logic [31:0]          o_found_frame,
    output logic [47:0]          o_found_capture,
    output logic                 o_found_key,
    output logic [23:0]          o_found_length,
    output logic [6:0]           o_held_frames,
    output logic [29:0]          o_held_bytes,
    output logic [31:0]          o_hit_total,
    output logic [31:0]          o_miss_total,
    output logic [31:0]          o_evicted_total
);
    typedef struct packed {
        logic [31:0] base;
        logic [15:0] count;
        logic [31:0] frame;
        logic [47:0] capture;
        logic        key;
        logic [47:0] stored;
        logic [23:0] length;
    } t_entry;

    t_entry r_mem [rfc_pkg::Depth];
    t_entry r_rd;
    t_entry r_in;
    logic [1:0] r_op;

    logic [rfc_pkg::PtrW-1:0] r_head;
    logic [rfc_pkg::CntW-1:0] r_occ;
    logic [rfc_pkg::CntW-1:0] r_off;
    logic [29:0] r_bytes;
    logic [31:0] r_hits, r_misses, r_evict;
    logic [6:0]  r_max;
    logic [31:0] r_ret;

    logic [rfc_pkg::PtrW:0]   w_sum;
    logic [rfc_pkg::PtrW-1:0] w_wslot;
    logic [rfc_pkg::PtrW-1:0] w_rslot;
    logic [rfc_pkg::PtrW-1:0] w_head_next;
    logic [rfc_pkg::CntW-1:0] w_rd_off;
    logic [31:0] w_idx;
    logic [47:0] w_age;

    // slot = head + offset mod depth
    function automatic logic [rfc_pkg::PtrW-1:0] slot(
        input logic [rfc_pkg::PtrW-1:0] h, input logic [rfc_pkg::CntW-1:0] o);
        logic [rfc_pkg::PtrW+1:0] s;
        s = {2'b00, h} + {1'b0, o};
        if (s >= (rfc_pkg::PtrW+2)'(rfc_pkg::Depth))
            s = s - (rfc_pkg::PtrW+2)'(rfc_pkg::Depth);
        return s[rfc_pkg::PtrW-1:0];
    endfunction

    assign w_sum = '0;
    assign w_wslot = slot(r_head, r_occ);
    assign w_head_next = slot(r_head, rfc_pkg::CntW'(1));
    // read address: head for expiry checks, offset for scans
    assign w_rd_off = i_cmd.scan_start ? '0 : (i_cmd.scan_step ? r_off + 1'b1 : r_off);
    assign w_rslot = i_cmd.rd_head ? (i_cmd.pop ? w_head_next : r_head)
                                   : slot(r_head, w_rd_off);

    assign w_idx = r_in.base - r_rd.base;
    assign w_age = r_in.stored - r_rd.stored;

    always_comb begin
        o_sts.empty_frame = (r_in.count == '0) || (r_in.length == '0);
        o_sts.full        = (r_occ == rfc_pkg::CntW'(rfc_pkg::Depth));
        o_sts.has_entries = (r_occ != '0);
        o_sts.expired     = (r_occ != '0) && (r_in.stored >= r_rd.stored)
                            && (w_age >= {16'd0, r_ret});
        o_sts.over_limit  = (r_max != '0) && ({1'b0, r_occ} > {1'b0, r_max});
        o_sts.match       = (w_idx < {16'd0, r_rd.count});
        o_sts.scan_last   = (r_off + 1'b1 >= r_occ);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write)
            r_mem[w_wslot] <= r_in;
        r_rd <= r_mem[w_rslot];
        if (i_cmd.latch) begin
            r_op        <= i_op;
            r_in.base   <= i_sequence_req;
            r_in.count  <= i_fragment_count;
            r_in.frame  <= i_frame_number;
            r_in.capture<= i_capture_time;
            r_in.key    <= i_key_frame;
            r_in.stored <= i_now_time;
            r_in.length <= i_data_length;
        end
        if (i_cmd.latch) begin
            o_hit            <= 1'b0;
            o_fragment_index <= '0;
            o_found_count    <= '0;
            o_found_frame    <= '0;
            o_found_capture  <= '0;
            o_found_key      <= 1'b0;
            o_found_length   <= '0;
        end else if (i_cmd.hit) begin
            o_hit            <= 1'b1;
            o_fragment_index <= w_idx[15:0];
            o_found_count    <= r_rd.count;
            o_found_frame    <= r_rd.frame;
            o_found_capture  <= r_rd.capture;
            o_found_key      <= r_rd.key;
            o_found_length   <= r_rd.length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_occ   <= '0;
            r_off   <= '0;
            r_bytes <= '0;
            r_hits  <= '0;
            r_misses<= '0;
            r_evict <= '0;
            r_max   <= '0;
            r_ret   <= rfc_pkg::RetentionReset;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rfc_pkg::CFG_MAX_FRAMES: r_max <= i_cfg_data[6:0];
                    rfc_pkg::CFG_RETENTION:  r_ret <= i_cfg_data;
                    default: ;
                endcase
            end
            r_off <= w_rd_off;
            if (i_cmd.clear) begin
                r_head  <= '0;
                r_occ   <= '0;
                r_bytes <= '0;
            end else if (i_cmd.pop) begin
                // pop uses the head length from the read register
                r_head  <= w_head_next;
                r_occ   <= r_occ - 1'b1;
                r_bytes <= r_bytes - {6'd0, r_rd.length};
                r_evict <= r_evict + 1'b1;
            end else if (i_cmd.write) begin
                r_occ   <= r_occ + 1'b1;
                r_bytes <= r_bytes + {6'd0, r_in.length};
            end
            if (i_cmd.hit)  r_hits   <= r_hits + 1'b1;
            if (i_cmd.miss) r_misses <= r_misses + 1'b1;
        end
    end

    assign o_op            = r_op;
    assign o_held_frames   = 7'(r_occ) | 7'(w_sum);
    assign o_held_bytes    = r_bytes;
    assign o_hit_total     = r_hits;
    assign o_miss_total    = r_misses;
    assign o_evicted_total = r_evict;

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= rfc_pkg::CntW'(rfc_pkg::Depth))
        else $error("occupancy above depth");
    a_pop_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.pop && i_cmd.write))
        else $error("pop and write together");
    a_evict_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop && !i_cmd.clear |=> r_evict == $past(r_evict) + 32'd1)
        else $error("eviction count not advanced");
`endif
endmodule

### rtl/rfc_ctrl.sv
// rfc_ctrl: operation sequencer of the frame cache
// depends on rfc_pkg
module rfc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_op_q,
    input  rfc_pkg::t_sts i_sts,
    output rfc_pkg::t_cmd o_cmd,
    output logic          o_out_valid,
    input  logic          i_out_stall
);
    // read data of the ring is registered and arrives in the cycle after its address
    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_HEAD, S_READ, S_EXPIRE, S_LIMIT, S_SCAN, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall)
            n_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.latch   = 1'b1;
                    o_cmd.rd_head = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_op_q)
                    rfc_pkg::OP_STORE: begin
                        if (i_sts.empty_frame) begin
                            n_state = S_DONE;
                        end else if (i_sts.full) begin
                            o_cmd.pop     = 1'b1;
                            o_cmd.rd_head = 1'b1;
                            n_state       = S_HEAD;
                        end else begin
                            n_state = S_HEAD;
                        end
                    end
                    rfc_pkg::OP_FIND: begin
                        if (i_sts.has_entries) begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end else begin
                            o_cmd.miss = 1'b1;
                            n_state    = S_DONE;
                        end
                    end
                    rfc_pkg::OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_HEAD: begin
                // append; into an empty ring the new slot is the head
                o_cmd.write = 1'b1;
                n_state     = S_READ;
            end
            S_READ: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_EXPIRE;
            end
            S_EXPIRE: begin
                // one expired head dropped per cycle, next head read behind it
                o_cmd.rd_head = 1'b1;
                if (i_sts.expired)
                    o_cmd.pop = 1'b1;
                else
                    n_state = S_LIMIT;
            end
            S_LIMIT: begin
                o_cmd.rd_head = 1'b1;
                if (i_sts.over_limit)
                    o_cmd.pop = 1'b1;
                else
                    n_state = S_DONE;
            end
            S_SCAN: begin
                if (i_sts.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_DONE;
                end else if (i_sts.scan_last) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

### rtl/retransmit_frame_cache.sv
// retransmit_frame_cache: top level of the retransmission frame cache
// depends on rfc_pkg, rfc_ctrl, rfc_dp
//
// Input channel i_in_valid / o_in_stall carries one beat per operation:
// store a frame, find a sequence number, or clear the cache. Output channel
// o_out_valid / i_out_stall returns one beat per operation with the find
// result (zero on a miss or for non-find operations) and the status counters.
// Configuration: i_cfg_we with i_cfg_idx 0 = max_frames, 1 = retention_ms.
// One operation is handled at a time. A clear, an ignored store, an unused
// op or a find on an empty ring goes from decode straight to the result; a
// store appends the frame, then pops each entry expired or over the frame
// limit (dropping the oldest entry of a full ring costs nothing extra); a
// find reads entries from the head one after another through the one read
// port of the entry memory. The next beat is taken when the result beat has
// left or is leaving. Reset empties the ring and clears counters and
// configuration to defaults; the entry memory is not cleared.
// While the receiver stalls, the result holds and no new beat is taken.
module retransmit_frame_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_sequence_req,
    input  logic [15:0] i_fragment_count,
    input  logic [31:0] i_frame_number,
    input  logic [47:0] i_capture_time,
    input  logic        i_key_frame,
    input  logic [23:0] i_data_length,
    input  logic [47:0] i_now_time,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic [15:0] o_fragment_index,
    output logic [15:0] o_found_count,
    output logic [31:0] o_found_frame,
    output logic [47:0] o_found_capture,
    output logic        o_found_key,
    output logic [23:0] o_found_length,
    output logic [6:0]  o_held_frames,
    output logic [29:0] o_held_bytes,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total,
    output logic [31:0] o_evicted_total
);
    rfc_pkg::t_cmd w_cmd;
    rfc_pkg::t_sts w_sts;
    logic [1:0]    w_op_q;

    rfc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall,
        .i_op_q(w_op_q), .i_sts(w_sts), .o_cmd(w_cmd),
        .o_out_valid, .i_out_stall
    );

    rfc_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_op, .i_sequence_req, .i_fragment_count, .i_frame_number,
        .i_capture_time, .i_key_frame, .i_data_length, .i_now_time,
        .o_op(w_op_q), .o_hit, .o_fragment_index, .o_found_count,
        .o_found_frame, .o_found_capture, .o_found_key, .o_found_length,
        .o_held_frames, .o_held_bytes, .o_hit_total, .o_miss_total,
        .o_evicted_total
    );
endmodule
